// ===== hdl/ipal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipal_pkg
// Shared types and constants of the IP prefix allowlist match block.
// ----------------------------------------------------------------------------
package ipal_pkg;

  localparam int DEF_ENTRIES = 16;
  localparam int SLOT_W      = 4;

  localparam logic       OP_LOAD  = 1'b0;
  localparam logic       OP_CHECK = 1'b1;

  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
  localparam logic [7:0] V6_MAX_PREFIX = 8'd128;

  // upper word of the low half of an IPv4-mapped IPv6 address
  localparam logic [31:0] MAPPED_TAG = 32'h0000_FFFF;

  // classified command handed from the front part to the back part
  typedef struct packed {
    logic              is_load;
    logic [SLOT_W-1:0] slot;
    logic              set_valid;  // load: write entry, else remove it
    logic              unknown;    // check: family cannot match anything
    logic              is_v6;
    logic [63:0]       key_hi;
    logic [63:0]       key_lo;
    logic [63:0]       mask_hi;
    logic [63:0]       mask_lo;
  } cmd_t;

  // one table word
  typedef struct packed {
    logic        is_v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
  } entry_t;

endpackage

// ===== hdl/ipal_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipal_front
// Classifies input items: saturates prefixes and builds masks for loads,
// unmaps IPv4-in-IPv6 addresses and flags unknown families for checks.
// ----------------------------------------------------------------------------
module ipal_front
  import ipal_pkg::*;
(
  input  logic              op,
  input  logic [SLOT_W-1:0] slot,
  input  logic              entry_on,
  input  logic [1:0]        addr_family,
  input  logic [63:0]       addr_hi,
  input  logic [63:0]       addr_lo,
  input  logic [7:0]        prefix_len,
  output cmd_t              cmd
);

  logic [7:0]   p4;
  logic [7:0]   p6;
  logic [31:0]  mask32;
  logic [127:0] mask128;
  logic         fam_ok;
  logic         is_mapped;

  always_comb begin
    p4        = (prefix_len > V4_MAX_PREFIX) ? V4_MAX_PREFIX : prefix_len;
    p6        = (prefix_len > V6_MAX_PREFIX) ? V6_MAX_PREFIX : prefix_len;
    mask32    = ~({32{1'b1}} >> p4[5:0]);
    mask128   = ~({128{1'b1}} >> p6);
    fam_ok    = (addr_family == FAM_V4) || (addr_family == FAM_V6);
    is_mapped = (addr_hi == 64'd0) && (addr_lo[63:32] == MAPPED_TAG);

    cmd           = '0;
    cmd.is_load   = (op == OP_LOAD);
    cmd.slot      = slot;
    cmd.set_valid = entry_on && fam_ok;
    cmd.unknown   = !fam_ok;

    if (op == OP_LOAD) begin
      cmd.is_v6 = (addr_family == FAM_V6);
      if (addr_family == FAM_V6) begin
        cmd.key_hi  = addr_hi;
        cmd.key_lo  = addr_lo;
        cmd.mask_hi = mask128[127:64];
        cmd.mask_lo = mask128[63:0];
      end else begin
        cmd.key_lo  = {32'd0, addr_lo[31:0]};
        cmd.mask_lo = {32'd0, mask32};
      end
    end else begin
      // mapped IPv6 addresses are judged against IPv4 entries
      if ((addr_family == FAM_V6) && !is_mapped) begin
        cmd.is_v6  = 1'b1;
        cmd.key_hi = addr_hi;
        cmd.key_lo = addr_lo;
      end else begin
        cmd.key_lo = {32'd0, addr_lo[31:0]};
      end
    end
  end

endmodule

// ===== hdl/ipal_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipal_fifo
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module ipal_fifo
  import ipal_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push && !full, pop && not_empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/ipal_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipal_back
// Holds the entry table, executes loads and scans the table for checks,
// one entry per cycle, and drives the result register.
// ----------------------------------------------------------------------------
module ipal_back
  import ipal_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              block,
  output logic [SLOT_W-1:0] hit_slot
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;

  logic               state;
  logic               out_free;
  logic               slot_ok;
  logic [IDX_W-1:0]   wr_idx;

  logic               key_v6;
  logic [63:0]        key_hi;
  logic [63:0]        key_lo;

  logic               issue_on;
  logic [IDX_W-1:0]   rd_idx;
  entry_t             rd_data;
  logic               cmp_on;
  logic               cmp_last;
  logic               ent_ok;
  logic [IDX_W-1:0]   cmp_idx;
  logic               hit;

  assign out_free = !out_valid || !out_stall;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid && out_free;
  assign slot_ok  = (int'(cmd.slot) < ENTRIES);
  assign wr_idx   = IDX_W'(cmd.slot);

  assign hit = cmp_on && ent_ok && (rd_data.is_v6 == key_v6) &&
               (((key_hi ^ rd_data.addr_hi) & rd_data.mask_hi) == 64'd0) &&
               (((key_lo ^ rd_data.addr_lo) & rd_data.mask_lo) == 64'd0);

  // table storage
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.is_load && slot_ok && cmd.set_valid) begin
      mem[wr_idx] <= '{is_v6:   cmd.is_v6,
                       addr_hi: cmd.key_hi,
                       addr_lo: cmd.key_lo,
                       mask_hi: cmd.mask_hi,
                       mask_lo: cmd.mask_lo};
    end
    rd_data <= mem[rd_idx];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      key_v6 <= cmd.is_v6;
      key_hi <= cmd.key_hi;
      key_lo <= cmd.key_lo;
    end
    if (issue_on) begin
      cmp_idx  <= rd_idx;
      cmp_last <= (rd_idx == IDX_W'(ENTRIES - 1));
      ent_ok   <= entry_valid[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      issue_on    <= 1'b0;
      cmp_on      <= 1'b0;
      rd_idx      <= '0;
      out_valid   <= 1'b0;
      block       <= 1'b0;
      hit_slot    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            if (cmd.is_load) begin
              if (slot_ok) begin
                entry_valid[wr_idx] <= cmd.set_valid;
              end
              out_valid <= 1'b1;
              block     <= 1'b0;
              hit_slot  <= '0;
            end else if (cmd.unknown) begin
              out_valid <= 1'b1;
              block     <= 1'b1;
              hit_slot  <= '0;
            end else begin
              // any waiting result leaves at this edge
              out_valid <= 1'b0;
              rd_idx    <= '0;
              issue_on  <= 1'b1;
              state     <= S_SCAN;
            end
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        S_SCAN: begin
          if (cmp_on && (hit || cmp_last)) begin
            out_valid <= 1'b1;
            block     <= !hit;
            hit_slot  <= hit ? SLOT_W'(cmp_idx) : '0;
            issue_on  <= 1'b0;
            cmp_on    <= 1'b0;
            state     <= S_IDLE;
          end else begin
            // issue one table read per cycle, compare the read word in the next cycle
            cmp_on <= issue_on;
            if (issue_on) begin
              if (rd_idx == IDX_W'(ENTRIES - 1)) begin
                issue_on <= 1'b0;
              end else begin
                rd_idx <= rd_idx + IDX_W'(1);
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/ip_prefix_allowlist_match_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_prefix_allowlist_match_top
// IPv4/IPv6 prefix allowlist: loads table entries and judges addresses.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_stall  | op slot entry_on addr_family
//           |           |                    | addr_hi addr_lo prefix_len
//   out     | output    | out_valid/out_stall| block hit_slot
//
// A load is done in the back part without a table scan. A check of a known
// family scans the table one entry per cycle through the registered table
// read port, ending at the first match or at the last entry. Other families
// answer without a scan. A two-entry queue takes items while the back part
// works or its result waits. Reset clears all entries to invalid.
// ----------------------------------------------------------------------------
module ip_prefix_allowlist_match_top
  import ipal_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [SLOT_W-1:0] slot,
  input  logic              entry_on,
  input  logic [1:0]        addr_family,
  input  logic [63:0]       addr_hi,
  input  logic [63:0]       addr_lo,
  input  logic [7:0]        prefix_len,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              block,
  output logic [SLOT_W-1:0] hit_slot
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_not_empty;
  logic q_pop;

  assign in_stall = q_full;

  ipal_front u_front (
    .op          (op),
    .slot        (slot),
    .entry_on    (entry_on),
    .addr_family (addr_family),
    .addr_hi     (addr_hi),
    .addr_lo     (addr_lo),
    .prefix_len  (prefix_len),
    .cmd         (front_cmd)
  );

  ipal_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  ipal_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .block     (block),
    .hit_slot  (hit_slot)
  );

endmodule
